// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/smvm_pkg.sv -----
// Types, constants and the saturation function of the sparse matrix-vector unit.
`default_nettype none

package smvm_pkg;

  localparam int VAL_W  = 32;   // Q16.16 value width
  localparam int FRAC_W = 16;   // fraction bits
  localparam int ACC_W  = 48;   // accumulator and truncated product width
  localparam int IDX_W  = 10;   // index field width
  localparam int ROW_W  = 16;   // row counter width

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Input command codes; the remaining code is ignored.
  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_NONZERO   = 2'd1,
    CMD_EMPTY_ROW = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             sat;
  } sat_t;

  // Clamp a signed accumulator to the signed value range.
  function automatic sat_t sat_acc(input logic [ACC_W-1:0] a);
    sat_t                   r;
    logic [ACC_W-VAL_W:0]   top;
    top = a[ACC_W-1:VAL_W-1];
    if (top == '0 || top == '1) begin
      r.value = a[VAL_W-1:0];
      r.sat   = 1'b0;
    end else if (a[ACC_W-1]) begin
      r.value = VAL_MIN;
      r.sat   = 1'b1;
    end else begin
      r.value = VAL_MAX;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/smvm_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module smvm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable with write strobe, otherwise register the read word.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/sparse_matrix_vector_multiply_unit.sv -----
// Complex CSR sparse matrix times dense vector, Q16.16, streaming.
//
// Input channel in_*: one transaction per command. in_tuser carries the
// command (load vector element, matrix nonzero, empty row), in_tdata the
// index and the complex value, in_tlast marks the last nonzero of a row.
// Loads write the vector store; a nonzero reads its column from the store,
// multiplies and accumulates; a row end or an empty row emits one result.
// Output channel out_*: one transaction per row with the row number and the
// saturated complex sum in out_tdata and the overflow flag in out_tuser.
// Throughput: one input transaction per cycle unless the receiver stalls.
// The single store port serves each accepted load and in-range nonzero once,
// and one complex multiply-accumulate stage finishes one nonzero per cycle.
// A row result passes from the transaction that ends the row through store
// read, product, accumulate and saturate into the output register.
// A loaded element may be used by the very next transaction.
// Reset clears the accumulators, the row counter and all pipeline valids;
// the vector store keeps no reset value and must be loaded before use.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"

module sparse_matrix_vector_multiply_unit
  import smvm_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // index[9:0], value_re[41:10], value_im[73:42], zero
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  input  wire logic        in_tlast,   // row_end
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // row_index[15:0], sum_re[47:16], sum_im[79:48]
  output logic [0:0]       out_tuser   // overflow[0]
);

  localparam int AW   = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int CW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int PW   = 2 * VAL_W;

  // ---------------- input decode ----------------
  logic                    en;
  logic                    accept;
  cmd_t                    cmd;
  logic [IDX_W-1:0]        in_index;
  logic [VAL_W-1:0]        in_re;
  logic [VAL_W-1:0]        in_im;
  logic [CW:0]             idx_ext;
  logic                    in_range;
  logic                    ram_en;
  logic                    ram_we;
  logic [PW-1:0]           ram_rdata;

  // Advance the whole pipeline unless a result waits on a stalled receiver.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  assign cmd      = cmd_t'(in_tuser);
  assign in_index = in_tdata[IDX_W-1:0];
  assign in_re    = in_tdata[IDX_W +: VAL_W];
  assign in_im    = in_tdata[IDX_W+VAL_W +: VAL_W];
  assign idx_ext  = (CW+1)'(in_index);
  assign in_range = idx_ext < (CW+1)'(VECTOR_DEPTH);

  // Store port: write on a load, read on a nonzero.
  always_comb begin
    ram_en = 1'b0;
    ram_we = 1'b0;
    unique case (cmd)
      CMD_LOAD: begin
        ram_en = accept && in_range;
        ram_we = 1'b1;
      end
      CMD_NONZERO: begin
        ram_en = accept && in_range;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  smvm_ram #(
    .WIDTH (PW),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (idx_ext[AW-1:0]),
    .wdata ({in_im, in_re}),
    .rdata (ram_rdata)
  );

  // ---------------- stage 1: store read in flight ----------------
  logic             s1_valid_r;
  logic             s1_mac_r;    // nonzero with a column inside the store
  logic             s1_emit_r;
  logic [VAL_W-1:0] s1_re_r;
  logic [VAL_W-1:0] s1_im_r;
  logic             s1_valid_nxt;
  logic             s1_emit_nxt;

  assign s1_valid_nxt = accept && (cmd == CMD_NONZERO || cmd == CMD_EMPTY_ROW);
  assign s1_emit_nxt  = (cmd == CMD_EMPTY_ROW) || in_tlast;

  // ---------------- stage 2: products ----------------
  logic                    s2_valid_r;
  logic                    s2_emit_r;
  logic [ACC_W-1:0]        p_rr_r;
  logic [ACC_W-1:0]        p_ii_r;
  logic [ACC_W-1:0]        p_ri_r;
  logic [ACC_W-1:0]        p_ir_r;
  logic signed [PW-1:0]    m_rr;
  logic signed [PW-1:0]    m_ii;
  logic signed [PW-1:0]    m_ri;
  logic signed [PW-1:0]    m_ir;
  logic [VAL_W-1:0]        x_re;
  logic [VAL_W-1:0]        x_im;

  assign x_re = ram_rdata[VAL_W-1:0];
  assign x_im = ram_rdata[PW-1:VAL_W];

  // Four independent signed products, one multiplier each.
  assign m_rr = $signed(s1_re_r) * $signed(x_re);
  assign m_ii = $signed(s1_im_r) * $signed(x_im);
  assign m_ri = $signed(s1_re_r) * $signed(x_im);
  assign m_ir = $signed(s1_im_r) * $signed(x_re);

  // ---------------- stage 3: accumulate ----------------
  logic [ACC_W-1:0] acc_re_r;
  logic [ACC_W-1:0] acc_im_r;
  logic [ACC_W-1:0] acc_re_nxt;
  logic [ACC_W-1:0] acc_im_nxt;
  logic [ROW_W-1:0] row_cnt_r;
  logic             s3_valid_r;
  logic [ROW_W-1:0] s3_row_r;
  logic [ACC_W-1:0] s3_re_r;
  logic [ACC_W-1:0] s3_im_r;

  assign acc_re_nxt = acc_re_r + p_rr_r - p_ii_r;
  assign acc_im_nxt = acc_im_r + p_ri_r + p_ir_r;

  // ---------------- stage 4: saturate into the output register ----------------
  sat_t             sat_re;
  sat_t             sat_im;
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [VAL_W-1:0] out_re_r;
  logic [VAL_W-1:0] out_im_r;
  logic             out_ovf_r;

  assign sat_re = sat_acc(s3_re_r);
  assign sat_im = sat_acc(s3_im_r);

  // Control state: valids, accumulators, row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      row_cnt_r   <= '0;
    end else if (en) begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r && s2_emit_r;
      out_valid_r <= s3_valid_r;
      if (s2_valid_r) begin
        if (s2_emit_r) begin
          acc_re_r  <= '0;
          acc_im_r  <= '0;
          row_cnt_r <= row_cnt_r + 1'b1;
        end else begin
          acc_re_r  <= acc_re_nxt;
          acc_im_r  <= acc_im_nxt;
        end
      end
    end
  end

  // Payload registers advance with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_mac_r  <= (cmd == CMD_NONZERO) && in_range;
      s1_emit_r <= s1_emit_nxt;
      s1_re_r   <= in_re;
      s1_im_r   <= in_im;

      s2_emit_r <= s1_emit_r;
      // Drop products for empty rows and columns beyond the store.
      p_rr_r    <= s1_mac_r ? m_rr[FRAC_W +: ACC_W] : '0;
      p_ii_r    <= s1_mac_r ? m_ii[FRAC_W +: ACC_W] : '0;
      p_ri_r    <= s1_mac_r ? m_ri[FRAC_W +: ACC_W] : '0;
      p_ir_r    <= s1_mac_r ? m_ir[FRAC_W +: ACC_W] : '0;

      s3_row_r  <= row_cnt_r;
      s3_re_r   <= acc_re_nxt;
      s3_im_r   <= acc_im_nxt;

      out_row_r <= s3_row_r;
      out_re_r  <= sat_re.value;
      out_im_r  <= sat_im.value;
      out_ovf_r <= sat_re.sat || sat_im.sat;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_im_r, out_re_r, out_row_r};
  assign out_tuser[0] = out_ovf_r;

  // ---------------- assertions ----------------
  `ASSERT_NEXT(a_row_advance, en && s2_valid_r && s2_emit_r,
    row_cnt_r == $past(row_cnt_r) + 1'b1, "row counter did not advance on emit")
  `ASSERT_NEXT(a_acc_clear, en && s2_valid_r && s2_emit_r,
    acc_re_r == '0 && acc_im_r == '0, "accumulators not cleared after emit")
  `ASSERT_IMPL(a_ovf_clamped, out_valid_r && out_ovf_r,
    out_re_r == VAL_MAX || out_re_r == VAL_MIN || out_im_r == VAL_MAX ||
    out_im_r == VAL_MIN, "overflow flagged without a clamped part")
  `ASSERT_NEXT(a_hold_stall, out_valid_r && !out_tready,
    s3_valid_r == $past(s3_valid_r) && acc_re_r == $past(acc_re_r),
    "pipeline moved while output stalled")

endmodule

`default_nettype wire

// ----- bench/sparse_matrix_vector_multiply_unit_tb.sv -----
// Self-checking testbench for the complex CSR sparse matrix-vector multiply unit.
`timescale 1ns / 1ps

module sparse_matrix_vector_multiply_unit_tb
  import smvm_pkg::*;
();

  // Command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 1024;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] re;
    logic [VAL_W-1:0] im;
    logic             ovf;
  } row_sum_t;

  // Tracks vector store, running sum and row number; queues expected row sums
  class row_sum_scoreboard;
    logic [VAL_W-1:0] vec_re [STORE_DEPTH];
    logic [VAL_W-1:0] vec_im [STORE_DEPTH];
    logic [ACC_W-1:0] acc_re;
    logic [ACC_W-1:0] acc_im;
    logic [ROW_W-1:0] row_num;
    row_sum_t         pending_sums [$];
    int               errors;

    function new();
      acc_re  = '0;
      acc_im  = '0;
      row_num = '0;
      errors  = 0;
    endfunction

    // Full signed product, keep bits 16 and up (floor toward minus infinity)
    function logic [ACC_W-1:0] trunc_mul(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic signed [2*VAL_W-1:0] p;
      p = $signed(a) * $signed(b);
      return p[2*VAL_W-1:FRAC_W];
    endfunction

    // Clamp a signed 48-bit sum into the signed value range
    function logic [VAL_W-1:0] clamp(logic [ACC_W-1:0] a, output logic hit);
      logic signed [ACC_W-1:0] s;
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      s   = a;
      hi  = (48'sd1 <<< (VAL_W - 1)) - 48'sd1;
      lo  = -(48'sd1 <<< (VAL_W - 1));
      hit = 1'b0;
      if (s > hi) begin
        hit = 1'b1;
        s   = hi;
      end else if (s < lo) begin
        hit = 1'b1;
        s   = lo;
      end
      return s[VAL_W-1:0];
    endfunction

    // Apply one accepted transaction to the predicted state
    function void note_input(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] re, logic [VAL_W-1:0] im, logic last);
      logic     emit;
      logic     hit_re;
      logic     hit_im;
      row_sum_t r;
      emit = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          vec_re[idx] = re;
          vec_im[idx] = im;
        end
        CMD_NONZERO: begin
          acc_re = acc_re + trunc_mul(re, vec_re[idx]) - trunc_mul(im, vec_im[idx]);
          acc_im = acc_im + trunc_mul(re, vec_im[idx]) + trunc_mul(im, vec_re[idx]);
          emit   = last;
        end
        CMD_EMPTY_ROW: begin
          emit = 1'b1;
        end
        default: ;
      endcase
      if (emit) begin
        r.row = row_num;
        r.re  = clamp(acc_re, hit_re);
        r.im  = clamp(acc_im, hit_im);
        r.ovf = hit_re | hit_im;
        pending_sums.push_back(r);
        acc_re  = '0;
        acc_im  = '0;
        row_num = row_num + 1'b1;
      end
    endfunction

    // Compare one accepted result with the oldest expected row sum
    function void check_result(logic [79:0] data, logic [0:0] user);
      row_sum_t x;
      if (pending_sums.size() == 0) begin
        $display("%0t unexpected result: expected none, actual row %0d re %h im %h ovf %0d",
                 $time, data[15:0], data[47:16], data[79:48], user[0]);
        errors++;
        return;
      end
      x = pending_sums.pop_front();
      if (data[15:0] !== x.row) begin
        $display("%0t row_index: expected %0d actual %0d", $time, x.row, data[15:0]);
        errors++;
      end
      if (data[47:16] !== x.re) begin
        $display("%0t sum_re row %0d: expected %h actual %h", $time, x.row, x.re, data[47:16]);
        errors++;
      end
      if (data[79:48] !== x.im) begin
        $display("%0t sum_im row %0d: expected %h actual %h", $time, x.row, x.im, data[79:48]);
        errors++;
      end
      if (user[0] !== x.ovf) begin
        $display("%0t overflow row %0d: expected %0d actual %0d", $time, x.row, x.ovf, user[0]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;

  int send_idle_pct = 17;
  int recv_idle_pct = 88;
  int hold_requests = 0;

  row_sum_scoreboard sb = new();

  // Columns loaded so far; nonzeros only read these
  bit              loaded [STORE_DEPTH];
  logic [IDX_W-1:0] loaded_cols [$];

  sparse_matrix_vector_multiply_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Drive out_tready: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one transaction with random leading gaps; return once accepted
  task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, im, re, idx};
    in_tuser  <= cmd;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, idx, re, im, last);
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] re,
                            input logic [VAL_W-1:0] im, input logic last);
    send_item(CMD_LOAD, idx, re, im, last);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
  endtask

  // Mix of extremes, full-range and small Q16.16 values
  function automatic logic [VAL_W-1:0] rand_value();
    int pick;
    int small_val;
    pick = $urandom_range(9);
    small_val = int'($urandom_range(1 << 20)) - (1 << 19);
    case (pick)
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: return small_val;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_col();
    return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
  endfunction

  // One row of nonzeros; the last one closes the row unless broken
  task automatic send_row(input int len, input logic close_row);
    logic real_only;
    real_only = ($urandom_range(3) == 0);
    for (int k = 0; k < len; k++) begin
      send_item(CMD_NONZERO, rand_col(), rand_value(), real_only ? '0 : rand_value(),
                close_row && (k == len - 1));
    end
  endtask

  // Mostly well-formed rows with random content, some loads and noise
  task automatic random_traffic(input int count);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        load_entry(IDX_W'($urandom_range(STORE_DEPTH - 1)), rand_value(), rand_value(),
                   1'($urandom_range(1)));
        done++;
      end else if (pick < 16) begin
        send_item(CMD_EMPTY_ROW, IDX_W'($urandom_range(STORE_DEPTH - 1)),
                  $urandom, $urandom, 1'($urandom_range(1)));
        done++;
      end else if (pick < 18) begin
        send_item(CMD_UNUSED, IDX_W'($urandom_range(STORE_DEPTH - 1)),
                  $urandom, $urandom, 1'($urandom_range(1)));
      end else if (pick < 21) begin
        // broken row: nonzeros cut off by an empty-row command
        len = $urandom_range(1, 3);
        send_row(len, 1'b0);
        send_item(CMD_EMPTY_ROW, '0, '0, '0, 1'b0);
        done += len + 1;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        send_row(len, 1'b1);
        done += len;
      end
    end
  endtask

  // Extremes, every command and the corner cases of the datapath
  task automatic directed_part();
    load_entry(10'd0, VAL_MAX, VAL_MIN, 1'b1);
    load_entry(10'd1023, VAL_MIN, VAL_MAX, 1'b0);
    load_entry(10'd1, 32'h0001_0000, 32'h0, 1'b0);
    load_entry(10'd2, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
    load_entry(10'd3, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    // empty rows with nothing pending, row end flag ignored on the second
    send_item(CMD_EMPTY_ROW, 10'd0, 32'h0, 32'h0, 1'b0);
    send_item(CMD_EMPTY_ROW, 10'd1023, VAL_MAX, VAL_MIN, 1'b1);
    send_item(CMD_NONZERO, 10'd1, 32'h0001_8000, 32'hFFFF_8000, 1'b1);
    // tiny operands: truncation toward minus infinity
    send_item(CMD_NONZERO, 10'd2, 32'h0000_0001, 32'h0000_0001, 1'b0);
    send_item(CMD_NONZERO, 10'd3, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    // saturation both ways
    send_item(CMD_NONZERO, 10'd0, VAL_MAX, 32'h0, 1'b1);
    send_item(CMD_NONZERO, 10'd1023, VAL_MIN, VAL_MIN, 1'b1);
    send_item(CMD_UNUSED, 10'd1023, VAL_MAX, VAL_MAX, 1'b1);
    // accumulator wraps past 48 bits
    for (int k = 0; k < 4; k++) send_item(CMD_NONZERO, 10'd0, VAL_MAX, VAL_MIN, k == 3);
    // empty row flushes a pending sum, next row starts from zero
    send_item(CMD_NONZERO, 10'd1, 32'h1234_5678, 32'h8765_4321, 1'b0);
    send_item(CMD_EMPTY_ROW, 10'd0, 32'h0, 32'h0, 1'b0);
    send_item(CMD_NONZERO, 10'd2, 32'h0002_0000, 32'h0, 1'b1);
    // overwrite then read on the very next transaction
    load_entry(10'd1, 32'hFFF0_0000, 32'h000F_FFFF, 1'b1);
    send_item(CMD_NONZERO, 10'd1, 32'h0003_0000, 32'hFFFD_0000, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    random_traffic(400);

    send_idle_pct = 88;
    recv_idle_pct = 17;
    random_traffic(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    random_traffic(400);

    in_tvalid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (sb.errors == 0) begin
      $display("sparse_matrix_vector_multiply_unit_tb: clean");
    end else begin
      $display("sparse_matrix_vector_multiply_unit_tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("sparse_matrix_vector_multiply_unit_tb: errors");
    $finish;
  end

endmodule
